// ===== src/note_on_off_pairing_unit_assert.svh =====
// Assertion macros for the note on/off pairing unit.
// Used inside modules that have clk and rst_n in scope; no other dependencies.
`ifndef NOTE_ON_OFF_PAIRING_UNIT_ASSERT_SVH
`define NOTE_ON_OFF_PAIRING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NOPU_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NOPU_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/nopu_pkg.sv =====
// Shared types and constants for the note on/off pairing unit.
// No dependencies.
`timescale 1ns / 1ps

package nopu_pkg;

    localparam int TRACK_W = 8;
    localparam int CHAN_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int TIME_W  = 24;
    localparam int OUTIDX_W = 16;
    localparam int KEY_W   = TRACK_W + CHAN_W + NOTE_W;

    // Result status codes
    localparam logic [1:0] STATUS_ON_STORED     = 2'd0;
    localparam logic [1:0] STATUS_ON_DROPPED    = 2'd1;
    localparam logic [1:0] STATUS_OFF_MATCHED   = 2'd2;
    localparam logic [1:0] STATUS_OFF_UNMATCHED = 2'd3;

    // Event function codes
    localparam logic FUNC_NOTE_ON  = 1'b0;
    localparam logic FUNC_NOTE_OFF = 1'b1;

    // Search key of a pending note
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [CHAN_W-1:0]  channel;
        logic [NOTE_W-1:0]  note;
    } key_t;

    // Compare result handed back to the controller
    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] duration;
    } match_t;

endpackage

// ===== src/nopu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nopu_ram #(
    parameter int WIDTH = 59,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/nopu_match.sv =====
// Key compare and duration compute for one pending entry read from the list.
// Depends on nopu_pkg.
`timescale 1ns / 1ps

module nopu_match (
    input  nopu_pkg::key_t                  entry_key,
    input  logic [nopu_pkg::TIME_W-1:0]     entry_time,
    input  nopu_pkg::key_t                  probe_key,
    input  logic [nopu_pkg::TIME_W-1:0]     probe_time,
    output nopu_pkg::match_t                result
);

    // Track, channel and note must all agree; duration wraps mod 2^24
    always_comb
    begin
        result.hit      = (entry_key == probe_key);
        result.duration = probe_time - entry_time;
    end

endmodule

// ===== src/note_on_off_pairing_unit.sv =====
// Note on/off pairing unit: pending note-on list kept in one RAM, searched
// newest first and compacted in place. A note on or an empty-list off has its
// result registered in the cycle after transfer; other offs report when the
// search hits or reaches the oldest entry. After a match, busy stays high while
// newer entries move down over the single RAM read port; no event is taken then.
// Reset: list empty at once, no clearing pass; done is the result strobe.
`timescale 1ns / 1ps

module note_on_off_pairing_unit #(
    parameter int PENDING_DEPTH = 128,
    parameter int INDEX_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic [15:0]                       event_index,
    input  logic [nopu_pkg::TRACK_W-1:0]      track_id,
    input  logic [nopu_pkg::CHAN_W-1:0]       channel,
    input  logic [nopu_pkg::NOTE_W-1:0]       note,
    input  logic [nopu_pkg::TIME_W-1:0]       event_time,
    output logic                              done,
    output logic [1:0]                        status,
    output logic [nopu_pkg::OUTIDX_W-1:0]     on_index,
    output logic [nopu_pkg::TIME_W-1:0]       duration
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int EW = INDEX_BITS + nopu_pkg::KEY_W + nopu_pkg::TIME_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT
    } state_t;

    state_t                         state_reg;
    logic [CW-1:0]                  count_reg;
    logic [AW-1:0]                  addr_reg;
    nopu_pkg::key_t                 key_reg;
    logic [nopu_pkg::TIME_W-1:0]    time_reg;
    logic                           done_reg;
    logic [1:0]                     status_reg;
    logic [nopu_pkg::OUTIDX_W-1:0]  on_index_reg;
    logic [nopu_pkg::TIME_W-1:0]    duration_reg;

    logic                           accept;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [EW-1:0]                  ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [EW-1:0]                  ram_rdata;
    nopu_pkg::key_t                 rd_key;
    logic [nopu_pkg::TIME_W-1:0]    rd_time;
    logic [INDEX_BITS-1:0]          rd_index;
    nopu_pkg::match_t               m;
    logic                           hit_is_newest;
    logic                           shift_last;
    nopu_pkg::key_t                 in_key;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    assign in_key.track   = track_id;
    assign in_key.channel = channel;
    assign in_key.note    = note;

    // Entry layout: {index, track, channel, note, time}
    assign rd_time  = ram_rdata[nopu_pkg::TIME_W-1:0];
    assign rd_key   = ram_rdata[nopu_pkg::TIME_W +: nopu_pkg::KEY_W];
    assign rd_index = ram_rdata[EW-1 -: INDEX_BITS];

    nopu_ram #(
        .WIDTH (EW),
        .DEPTH (PENDING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nopu_match u_match (
        .entry_key  (rd_key),
        .entry_time (rd_time),
        .probe_key  (key_reg),
        .probe_time (time_reg),
        .result     (m)
    );

    // Matched entry is the last one: nothing to move
    assign hit_is_newest = ((CW'(addr_reg) + CW'(1)) == count_reg);
    // Shift ends after writing the slot just below the new count
    assign shift_last    = ((CW'(addr_reg) + CW'(1)) == count_reg);

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = {INDEX_BITS'(event_index), track_id, channel, note, event_time};
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (func == nopu_pkg::FUNC_NOTE_ON) && (count_reg != DEPTH_C))
                begin
                    ram_we = 1'b1;
                end
                ram_raddr = AW'(count_reg - CW'(1));
            end
            S_SEARCH:
            begin
                if (m.hit)
                begin
                    ram_raddr = addr_reg + AW'(1);
                end
                else
                begin
                    ram_raddr = addr_reg - AW'(1);
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = addr_reg + AW'(2);
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // Sequencer and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            addr_reg     <= '0;
            key_reg      <= '0;
            time_reg     <= '0;
            done_reg     <= 1'b0;
            status_reg   <= nopu_pkg::STATUS_ON_STORED;
            on_index_reg <= '0;
            duration_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg      <= in_key;
                        time_reg     <= event_time;
                        on_index_reg <= '0;
                        duration_reg <= '0;
                        if (func == nopu_pkg::FUNC_NOTE_ON)
                        begin
                            done_reg <= 1'b1;
                            if (count_reg != DEPTH_C)
                            begin
                                status_reg <= nopu_pkg::STATUS_ON_STORED;
                                count_reg  <= count_reg + CW'(1);
                            end
                            else
                            begin
                                status_reg <= nopu_pkg::STATUS_ON_DROPPED;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= nopu_pkg::STATUS_OFF_UNMATCHED;
                        end
                        else
                        begin
                            addr_reg  <= AW'(count_reg - CW'(1));
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (m.hit)
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= nopu_pkg::STATUS_OFF_MATCHED;
                        on_index_reg <= nopu_pkg::OUTIDX_W'(rd_index);
                        duration_reg <= m.duration;
                        count_reg    <= count_reg - CW'(1);
                        state_reg    <= hit_is_newest ? S_IDLE : S_SHIFT;
                    end
                    else if (addr_reg == '0)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= nopu_pkg::STATUS_OFF_UNMATCHED;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg - AW'(1);
                    end
                end
                S_SHIFT:
                begin
                    if (shift_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign on_index = on_index_reg;
    assign duration = duration_reg;

    // Checks
    `include "note_on_off_pairing_unit_assert.svh"

    `NOPU_ASSERT_NXT(a_full_drop, accept && !func && (count_reg == DEPTH_C), done && (status == nopu_pkg::STATUS_ON_DROPPED) && (count_reg == DEPTH_C), "note on with full list not dropped")
    `NOPU_ASSERT_IMP(a_zero_fields, done && (status != nopu_pkg::STATUS_OFF_MATCHED), (on_index == '0) && (duration == '0), "nonzero fields without a match")
    `NOPU_ASSERT_IMP(a_shift_bound, state_reg == S_SHIFT, (CW'(addr_reg) + CW'(1)) <= count_reg, "compaction ran past list end")
    `NOPU_ASSERT_NXT(a_hit_result, (state_reg == S_SEARCH) && m.hit, done && (status == nopu_pkg::STATUS_OFF_MATCHED) && (count_reg == $past(count_reg) - CW'(1)), "match not reported or count not reduced")

endmodule
